// ===== hdl/ffca_pkg.sv =====
package ffca_pkg;

    localparam int unsigned GRAIN = 16;
    localparam logic [31:0] GRAIN_MASK = 32'h0000_000F;

    localparam logic [1:0] REG_FREE_START = 2'd0;
    localparam logic [1:0] REG_HOLE_START = 2'd1;
    localparam logic [1:0] REG_HOLE_END   = 2'd2;
    localparam logic [1:0] REG_MEM_END    = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [31:0] RST_FREE_START = 32'h0000_0000;
    localparam logic [31:0] RST_HOLE_START = 32'h000A_0000;
    localparam logic [31:0] RST_HOLE_END   = 32'h0010_0000;
    localparam logic [31:0] RST_MEM_END    = 32'h0040_0000;

    function automatic logic [31:0] round16(input logic [31:0] x);
        logic [31:0] s;
        s = x + GRAIN_MASK;
        return s & ~GRAIN_MASK;
    endfunction

endpackage

// ===== hdl/ffca_blocks.sv =====
// Allocated block table. Entries are read one per cycle through a registered
// port; validity lives in flip-flops so a rebuild clears all blocks at once.
module ffca_blocks #(
    parameter int MAX_BLOCKS = 64,
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_start,
    output logic [31:0]   o_rd_size,
    output logic          o_rd_valid,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_start,
    input  logic [31:0]   i_wr_size,
    input  logic          i_inv_en,
    input  logic [AW-1:0] i_inv_addr
);
    logic [31:0] r_start [MAX_BLOCKS];
    logic [31:0] r_size  [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_start[i_wr_addr] <= i_wr_start;
            r_size[i_wr_addr]  <= i_wr_size;
        end
        o_rd_start <= r_start[i_rd_addr];
        o_rd_size  <= r_size[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en)
                r_valid[i_wr_addr] <= 1'b1;
            if (i_inv_en)
                r_valid[i_inv_addr] <= 1'b0;
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end
endmodule

// ===== hdl/first_fit_coalescing_allocator_top.sv =====
// Channel   Direction  Handshake           Payload
// command   in         i_start / o_busy    i_func, i_request_size, i_release_address
// result    out        o_done (one cycle)  o_data_address, o_success
// config    in         i_cfg_valid/ready   i_cfg_index, i_cfg_data
//
// An item walks the block table (one entry per cycle, registered read) and then
// the segment table (one entry per cycle); inserts shift the segment memory one
// entry per cycle and removals one entry per pass through S_AREM and S_REMW.
// Request time is set mainly by the table walks, each through a single read port.
// Reset or any config write rebuilds the two initial segments (S_INIT0, S_INIT1) and
// clears all blocks; o_busy stays high meanwhile. Results cannot be stalled.
module first_fit_coalescing_allocator_top #(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_BLOCKS = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_release_address,
    output logic        o_done,
    output logic [31:0] o_data_address,
    output logic        o_success,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int BAW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int BCW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [SCW-1:0] SEG_MAX = SCW'(MAX_SEGMENTS);
    localparam logic [BCW-1:0] BLK_MAX = BCW'(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE,
        S_SLOT, S_NEED, S_AWALK, S_AHIT, S_AREM,
        S_FWALK, S_FHIT, S_PWALK, S_PPREV, S_PEVAL, S_PCUR, S_PMERGE,
        S_INS, S_INSW, S_REMW, S_DONE
    } t_state;

    t_state r_state;
    logic [31:0] r_cfg [4];
    logic        r_func;
    logic [31:0] r_req, r_addr;
    logic [SCW-1:0] r_cnt, r_i, r_j;
    logic [BCW-1:0] r_b;
    logic [BAW-1:0] r_slot;
    logic [32:0] r_need;
    logic [31:0] r_bs, r_bz, r_ps, r_cz, r_sum;
    logic        r_prev_adj;
    logic        r_ok;
    logic [31:0] r_res;

    // Segment memory: one write, one registered read.
    logic [31:0] r_seg_s [MAX_SEGMENTS];
    logic [31:0] r_seg_z [MAX_SEGMENTS];
    logic [31:0] r_rd_s, r_rd_z;
    logic [SAW-1:0] w_rd_a, w_wr_a;
    logic        w_we;
    logic [31:0] w_wd_s, w_wd_z;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_seg_s[w_wr_a] <= w_wd_s;
            r_seg_z[w_wr_a] <= w_wd_z;
        end
        r_rd_s <= r_seg_s[w_rd_a];
        r_rd_z <= r_seg_z[w_rd_a];
    end

    logic [BAW-1:0] w_b_rd;
    logic [31:0] w_b_s, w_b_z;
    logic        w_b_v, w_b_we, w_b_inv, w_clear;

    ffca_blocks #(.MAX_BLOCKS(MAX_BLOCKS), .AW(BAW)) u_blocks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(w_clear),
        .i_rd_addr(w_b_rd), .o_rd_start(w_b_s), .o_rd_size(w_b_z), .o_rd_valid(w_b_v),
        .i_wr_en(w_b_we), .i_wr_addr(r_slot), .i_wr_start(r_bs), .i_wr_size(r_bz),
        .i_inv_en(w_b_inv), .i_inv_addr(r_b[BAW-1:0])
    );

    // A command beat takes precedence over a register write in the same cycle.
    logic w_cfg_wr;
    assign o_cfg_ready = (r_state == S_IDLE) && i_rst_n && !i_start;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;
    assign w_clear = w_cfg_wr;
    assign o_busy = (r_state != S_IDLE) || !i_rst_n;

    logic [31:0] w_seg1_s;
    assign w_seg1_s = ffca_pkg::round16(r_cfg[ffca_pkg::REG_HOLE_END]);

    logic w_rd_end;
    logic w_next_adj;
    assign w_rd_end = (r_rd_s + r_rd_z) == r_bs;
    assign w_next_adj = (r_i < r_cnt) && ((r_bs + r_bz) == r_rd_s);

    // Read addresses are presented in the cycle before the compare uses their data.
    always_comb begin
        w_rd_a = r_i[SAW-1:0];
        w_b_rd = r_b[BAW-1:0];
        w_we = 1'b0;
        w_wr_a = r_i[SAW-1:0];
        w_wd_s = r_rd_s;
        w_wd_z = r_rd_z;
        w_b_we = 1'b0;
        w_b_inv = 1'b0;
        case (r_state)
            S_INIT0: begin
                w_we = 1'b1;
                w_wr_a = '0;
                w_wd_s = ffca_pkg::round16(r_cfg[ffca_pkg::REG_FREE_START]);
                w_wd_z = ffca_pkg::round16(r_cfg[ffca_pkg::REG_HOLE_START]
                                           - r_cfg[ffca_pkg::REG_FREE_START]);
            end
            S_INIT1: begin
                w_we = 1'b1;
                w_wr_a = SAW'(1);
                w_wd_s = w_seg1_s;
                w_wd_z = ffca_pkg::round16(r_cfg[ffca_pkg::REG_MEM_END] - w_seg1_s);
            end
            S_AHIT: begin
                w_b_we = 1'b1;
                if (r_cz != r_need[31:0]) begin
                    w_we = 1'b1;
                    w_wd_s = r_bs + r_need[31:0];
                    w_wd_z = r_cz - r_need[31:0];
                end
            end
            S_REMW: begin
                w_we = 1'b1;
                w_wr_a = r_i[SAW-1:0] - SAW'(1);
            end
            S_AREM: w_rd_a = r_i[SAW-1:0] + SAW'(1);
            S_PMERGE: begin
                w_rd_a = r_i[SAW-1:0] + SAW'(1);
                // Both neighbors touch: the previous segment absorbs block and next.
                if (w_next_adj && r_prev_adj) begin
                    w_we = 1'b1;
                    w_wr_a = r_i[SAW-1:0] - SAW'(1);
                    w_wd_s = r_ps;
                    w_wd_z = r_sum + r_rd_z;
                    w_b_inv = 1'b1;
                end
            end
            S_PPREV: w_rd_a = r_i[SAW-1:0] - SAW'(1);
            S_PEVAL: begin
                w_rd_a = r_i[SAW-1:0];
            end
            S_PCUR: begin
                w_b_inv = 1'b1;
                w_we = 1'b1;
                if (r_prev_adj) begin
                    w_wr_a = r_i[SAW-1:0] - SAW'(1);
                    w_wd_s = r_ps;
                    w_wd_z = r_sum;
                end else begin
                    w_wd_s = r_bs;
                    w_wd_z = r_sum;
                end
            end
            S_INS: w_rd_a = r_cnt[SAW-1:0] - SAW'(1);
            S_INSW: begin
                w_we = 1'b1;
                if (r_j == r_i) begin
                    w_wr_a = r_i[SAW-1:0];
                    w_wd_s = r_bs;
                    w_wd_z = r_bz;
                    w_b_inv = 1'b1;
                end else begin
                    w_wr_a = r_j[SAW-1:0];
                    w_rd_a = r_j[SAW-1:0] - SAW'(2);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
            r_cfg[0] <= ffca_pkg::RST_FREE_START;
            r_cfg[1] <= ffca_pkg::RST_HOLE_START;
            r_cfg[2] <= ffca_pkg::RST_HOLE_END;
            r_cfg[3] <= ffca_pkg::RST_MEM_END;
            r_cnt <= SCW'(2);
            o_done <= 1'b0;
            o_success <= 1'b0;
            o_data_address <= '0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_INIT0: r_state <= S_INIT1;
                S_INIT1: begin
                    r_cnt <= SCW'(2);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_cfg_wr) begin
                        r_cfg[i_cfg_index] <= i_cfg_data;
                        r_state <= S_INIT0;
                    end else if (i_start) begin
                        r_func <= i_func;
                        r_req <= i_request_size;
                        r_addr <= i_release_address;
                        r_b <= '0;
                        r_i <= '0;
                        r_ok <= 1'b0;
                        r_res <= '0;
                        if (i_func == ffca_pkg::FUNC_ALLOC)
                            r_state <= (i_request_size == '0) ? S_DONE : S_SLOT;
                        else
                            r_state <= (i_release_address == '0) ? S_DONE : S_FWALK;
                    end
                end
                // Search for a free block slot; the block table read is registered.
                S_SLOT: begin
                    if (r_b != '0 && !w_b_v) begin
                        r_slot <= BAW'(r_b - BCW'(1));
                        r_state <= S_NEED;
                    end else if (r_b == BLK_MAX) begin
                        r_state <= S_DONE;
                    end else
                        r_b <= r_b + BCW'(1);
                end
                S_NEED: begin
                    r_need <= (({1'b0, r_req} + 33'd15) & ~33'd15) + {1'b0, HDR};
                    r_i <= '0;
                    r_state <= S_AWALK;
                end
                S_AWALK: begin
                    // r_i addresses the entry whose data arrives next cycle.
                    r_i <= r_i + SCW'(1);
                    if (r_i != '0 && r_need <= {1'b0, r_rd_z}) begin
                        r_i <= r_i - SCW'(1);
                        r_bs <= r_rd_s;
                        r_cz <= r_rd_z;
                        r_bz <= r_need[31:0];
                        r_state <= S_AHIT;
                    end else if (r_i >= r_cnt || r_i == SEG_MAX)
                        r_state <= S_DONE;
                end
                S_AHIT: begin
                    r_ok <= 1'b1;
                    r_res <= r_bs + HDR;
                    if (r_cz == r_need[31:0])
                        r_state <= S_AREM;
                    else
                        r_state <= S_DONE;
                end
                S_AREM: begin
                    // Shift entries above r_i down one place.
                    if (r_i + SCW'(1) >= r_cnt) begin
                        r_cnt <= r_cnt - SCW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + SCW'(1);
                        r_state <= S_REMW;
                    end
                end
                S_REMW: r_state <= S_AREM;
                S_FWALK: begin
                    if (r_b != '0 && w_b_v && (w_b_s + HDR) == r_addr) begin
                        r_b <= r_b - BCW'(1);
                        r_bs <= w_b_s;
                        r_bz <= w_b_z;
                        r_i <= '0;
                        r_state <= S_PWALK;
                    end else if (r_b == BLK_MAX)
                        r_state <= S_DONE;
                    else
                        r_b <= r_b + BCW'(1);
                end
                S_PWALK: begin
                    if (r_i != '0 && r_bs <= r_rd_s) begin
                        r_i <= r_i - SCW'(1);
                        r_state <= S_PPREV;
                    end else if (r_i >= r_cnt) begin
                        r_i <= r_cnt;
                        r_state <= S_PPREV;
                    end else
                        r_i <= r_i + SCW'(1);
                end
                S_PPREV: r_state <= S_PEVAL;
                S_PEVAL: begin
                    r_ps <= r_rd_s;
                    r_sum <= r_rd_z + r_bz;
                    r_prev_adj <= (r_i != '0) && w_rd_end;
                    r_state <= S_PMERGE;
                end
                S_PMERGE: begin
                    // Current segment data (at r_i) is now on the read port.
                    if (w_next_adj) begin
                        if (r_prev_adj) begin
                            r_ok <= 1'b1;
                            r_state <= S_AREM;
                        end else begin
                            r_sum <= r_bz + r_rd_z;
                            r_state <= S_PCUR;
                        end
                    end else if (r_prev_adj)
                        r_state <= S_PCUR;
                    else if (r_cnt >= SEG_MAX)
                        r_state <= S_DONE;
                    else
                        r_state <= S_INS;
                end
                S_PCUR: begin
                    r_ok <= 1'b1;
                    r_state <= S_DONE;
                end
                S_INS: begin
                    r_j <= r_cnt;
                    r_cnt <= r_cnt + SCW'(1);
                    r_state <= S_INSW;
                end
                S_INSW: begin
                    if (r_j == r_i) begin
                        r_ok <= 1'b1;
                        r_state <= S_DONE;
                    end else
                        r_j <= r_j - SCW'(1);
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    o_success <= r_ok;
                    o_data_address <= (r_func == ffca_pkg::FUNC_ALLOC) ? r_res : '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_INIT0;
            endcase
        end
    end

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy);
    a_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE));
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SEG_MAX);
    a_cfg_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cfg_wr && i_start));
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int SEG_DEPTH = 64;
    localparam int BLK_DEPTH = 64;
    localparam logic [31:0] HDR = 32'd16;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef enum logic [1:0] {OP_ALLOC, OP_FREE_LIVE, OP_FREE_ANY} t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic [31:0] size;
        logic [31:0] addr;
        int unsigned pick;
    } t_request;

    typedef struct {
        logic [31:0] addr;
        logic        ok;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_func = ffca_pkg::FUNC_ALLOC;
    logic [31:0] i_request_size = '0;
    logic [31:0] i_release_address = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = ffca_pkg::REG_FREE_START;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_done;
    logic [31:0] o_data_address;
    logic        o_success;
    logic        o_cfg_ready;

    first_fit_coalescing_allocator_top uut (.*);

    // Mirror of the allocator state.
    logic [31:0] cfg_reg [4];
    logic [31:0] seg_start [SEG_DEPTH];
    logic [31:0] seg_size [SEG_DEPTH];
    int          seg_cnt;
    logic [31:0] blk_start [BLK_DEPTH];
    logic [31:0] blk_size [BLK_DEPTH];
    logic        blk_valid [BLK_DEPTH];
    logic [31:0] live_addrs [$];

    t_request    pending_reqs [$];
    t_outcome    expected_outcomes [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] grain_up(input logic [31:0] x);
        logic [31:0] s;
        s = x + 32'd15;
        return s & ~32'd15;
    endfunction

    function automatic void rebuild_tables();
        for (int i = 0; i < SEG_DEPTH; i++) begin
            seg_start[i] = '0;
            seg_size[i] = '0;
        end
        for (int i = 0; i < BLK_DEPTH; i++) begin
            blk_valid[i] = 1'b0;
        end
        seg_start[0] = grain_up(cfg_reg[ffca_pkg::REG_FREE_START]);
        seg_size[0] = grain_up(cfg_reg[ffca_pkg::REG_HOLE_START]
                               - cfg_reg[ffca_pkg::REG_FREE_START]);
        seg_start[1] = grain_up(cfg_reg[ffca_pkg::REG_HOLE_END]);
        seg_size[1] = grain_up(cfg_reg[ffca_pkg::REG_MEM_END] - seg_start[1]);
        seg_cnt = 2;
        live_addrs.delete();
    endfunction

    function automatic void drop_segment(input int pos);
        for (int i = pos; i + 1 < seg_cnt; i++) begin
            seg_start[i] = seg_start[i + 1];
            seg_size[i] = seg_size[i + 1];
        end
        seg_cnt--;
    endfunction

    function automatic t_outcome carve_block(input logic [31:0] req);
        t_outcome    res;
        logic [63:0] need;
        logic [31:0] base;
        int          slot;
        res.addr = '0;
        res.ok = 1'b0;
        slot = -1;
        if (req == 0) return res;
        for (int i = 0; i < BLK_DEPTH; i++) begin
            if (!blk_valid[i]) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) return res;
        need = ((64'(req) + 64'd15) & ~64'd15) + 64'(HDR);
        for (int i = 0; i < seg_cnt; i++) begin
            if (need <= 64'(seg_size[i])) begin
                base = seg_start[i];
                if (64'(seg_size[i]) == need) begin
                    drop_segment(i);
                end else begin
                    seg_start[i] = base + need[31:0];
                    seg_size[i] = seg_size[i] - need[31:0];
                end
                blk_start[slot] = base;
                blk_size[slot] = need[31:0];
                blk_valid[slot] = 1'b1;
                res.addr = base + HDR;
                res.ok = 1'b1;
                if (res.addr != 0) live_addrs.push_back(res.addr);
                return res;
            end
        end
        return res;
    endfunction

    function automatic logic return_block(input logic [31:0] a);
        int          b;
        int          pos;
        logic [31:0] bs;
        logic [31:0] bz;
        logic [31:0] prev_end;
        logic [31:0] blk_end;
        logic        prev_adj;
        logic        next_adj;
        b = -1;
        if (a == 0) return 1'b0;
        for (int i = 0; i < BLK_DEPTH; i++) begin
            if (blk_valid[i] && blk_start[i] + HDR == a) begin
                b = i;
                break;
            end
        end
        if (b < 0) return 1'b0;
        bs = blk_start[b];
        bz = blk_size[b];
        pos = seg_cnt;
        for (int p = 0; p < seg_cnt; p++) begin
            if (bs <= seg_start[p]) begin
                pos = p;
                break;
            end
        end
        prev_adj = 1'b0;
        if (pos > 0) begin
            prev_end = seg_start[pos - 1] + seg_size[pos - 1];
            prev_adj = (prev_end == bs);
        end
        blk_end = bs + bz;
        next_adj = (pos < seg_cnt) && (blk_end == seg_start[pos]);
        if (prev_adj && next_adj) begin
            seg_size[pos - 1] = seg_size[pos - 1] + bz + seg_size[pos];
            drop_segment(pos);
        end else if (prev_adj) begin
            seg_size[pos - 1] = seg_size[pos - 1] + bz;
        end else if (next_adj) begin
            seg_start[pos] = bs;
            seg_size[pos] = seg_size[pos] + bz;
        end else begin
            if (seg_cnt >= SEG_DEPTH) return 1'b0;
            for (int i = seg_cnt; i > pos; i--) begin
                seg_start[i] = seg_start[i - 1];
                seg_size[i] = seg_size[i - 1];
            end
            seg_start[pos] = bs;
            seg_size[pos] = bz;
            seg_cnt++;
        end
        blk_valid[b] = 1'b0;
        for (int i = 0; i < live_addrs.size(); i++) begin
            if (live_addrs[i] == a) begin
                live_addrs.delete(i);
                break;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_outcome predict_outcome(input logic func, input logic [31:0] size,
                                                 input logic [31:0] addr);
        t_outcome res;
        if (func == ffca_pkg::FUNC_ALLOC) begin
            res = carve_block(size);
        end else begin
            res.addr = '0;
            res.ok = return_block(addr);
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(4, 1);
        return $urandom_range(120, 20);
    endfunction

    // Command driver: one beat at a time, random idle after each accepted beat.
    always @(posedge i_clk) begin
        t_request req;
        logic     accepted;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_left = 0;
        end else begin
            accepted = i_start && !o_busy;
            if (accepted) begin
                expected_outcomes.push_back(
                    predict_outcome(i_func, i_request_size, i_release_address));
                gap_left = pick_gap();
            end
            if (accepted || !i_start) begin
                if (gap_left > 0 && !accepted) gap_left--;
                if (gap_left == 0 && pending_reqs.size() > 0) begin
                    req = pending_reqs.pop_front();
                    i_start <= 1'b1;
                    i_request_size <= req.size;
                    if (req.kind == OP_ALLOC) begin
                        i_func <= ffca_pkg::FUNC_ALLOC;
                        i_release_address <= req.addr;
                    end else begin
                        i_func <= ffca_pkg::FUNC_FREE;
                        if (req.kind == OP_FREE_LIVE && live_addrs.size() > 0)
                            i_release_address <= live_addrs[req.pick % live_addrs.size()];
                        else
                            i_release_address <= req.addr;
                    end
                end else if (accepted) begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n && o_done) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result beat: data_address=%h success=%b",
                       o_data_address, o_success);
                error_count++;
            end else begin
                exp_res = expected_outcomes.pop_front();
                if (o_data_address !== exp_res.addr) begin
                    $error("data_address: expected %h, actual %h", exp_res.addr,
                           o_data_address);
                    error_count++;
                end
                if (o_success !== exp_res.ok) begin
                    $error("success: expected %b, actual %b", exp_res.ok, o_success);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void queue_req(input t_op_kind kind, input logic [31:0] size,
                                      input logic [31:0] addr, input int unsigned pick);
        t_request r;
        r.kind = kind;
        r.size = size;
        r.addr = addr;
        r.pick = pick;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [31:0] random_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(256, 1);
        if (r < 85) return $urandom_range(8192, 257);
        if (r < 90) return $urandom();
        if (r < 95) return '0;
        return 32'hFFFF_FFFF - $urandom_range(40);
    endfunction

    function automatic void queue_random(input int count, input int alloc_pct);
        int unsigned r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < alloc_pct)
                queue_req(OP_ALLOC, random_size(), $urandom(), 0);
            else if (r < 93)
                queue_req(OP_FREE_LIVE, $urandom(), $urandom(), $urandom());
            else if (r < 96)
                queue_req(OP_FREE_ANY, $urandom(), $urandom(), 0);
            else if (r < 98)
                queue_req(OP_FREE_ANY, $urandom(), '0, 0);
            else
                queue_req(OP_FREE_ANY, $urandom(), $urandom_range(4096) << 4, 0);
        end
    endfunction

    // Waits until the block has answered everything that was sent.
    // Sampled on the falling edge so the driver's updates have settled.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || i_start || expected_outcomes.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_reg[idx] = val;
        rebuild_tables();
    endtask

    task automatic write_all(input logic [31:0] fs, input logic [31:0] hs,
                             input logic [31:0] he, input logic [31:0] me);
        write_reg(ffca_pkg::REG_FREE_START, fs);
        write_reg(ffca_pkg::REG_HOLE_START, hs);
        write_reg(ffca_pkg::REG_HOLE_END, he);
        write_reg(ffca_pkg::REG_MEM_END, me);
    endtask

    initial begin
        cfg_reg[ffca_pkg::REG_FREE_START] = ffca_pkg::RST_FREE_START;
        cfg_reg[ffca_pkg::REG_HOLE_START] = ffca_pkg::RST_HOLE_START;
        cfg_reg[ffca_pkg::REG_HOLE_END] = ffca_pkg::RST_HOLE_END;
        cfg_reg[ffca_pkg::REG_MEM_END] = ffca_pkg::RST_MEM_END;
        rebuild_tables();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero size, coalescing on each side, exact fit, null and unknown frees.
        queue_req(OP_ALLOC, 32'd0, '0, 0);
        queue_req(OP_ALLOC, 32'd16, '0, 0);
        queue_req(OP_ALLOC, 32'd32, '0, 0);
        queue_req(OP_ALLOC, 32'd1, '0, 0);
        queue_req(OP_FREE_LIVE, '0, '0, 0);
        queue_req(OP_FREE_LIVE, '0, '0, 1);
        queue_req(OP_FREE_LIVE, '0, '0, 0);
        queue_req(OP_FREE_ANY, '0, '0, 0);
        queue_req(OP_FREE_ANY, '0, 32'h0001_2345, 0);
        queue_req(OP_ALLOC, 32'hFFFF_FFFF, '0, 0);
        queue_req(OP_ALLOC, 32'hFFFF_FFF0, '0, 0);
        queue_req(OP_ALLOC, 32'h0009_FFF0, '0, 0);
        queue_req(OP_ALLOC, 32'd17, '0, 0);
        queue_req(OP_FREE_LIVE, '0, '0, 0);
        queue_req(OP_FREE_LIVE, '0, '0, 0);
        queue_req(OP_FREE_ANY, '0, 32'h0000_0010, 0);
        queue_random(250, 60);
        drain();

        // Small regions: no-fit and a full block table are frequent here.
        write_all(32'h0000_1003, 32'h0000_3000, 32'h0000_3001, 32'h0000_6000);
        queue_random(250, 55);
        drain();

        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(30, 70);
        drain();
        write_all('0, '0, '0, '0);
        queue_random(30, 70);
        drain();

        // Wrapped first region: the first allocation gets data address zero.
        write_all(32'hFFFF_FFF0, 32'h0000_FFF0, 32'h0002_0000, 32'h0004_0000);
        queue_req(OP_ALLOC, 32'd1, '0, 0);
        queue_req(OP_FREE_ANY, '0, '0, 0);
        queue_random(250, 55);
        drain();

        write_all(ffca_pkg::RST_FREE_START, ffca_pkg::RST_HOLE_START,
                  ffca_pkg::RST_HOLE_END, ffca_pkg::RST_MEM_END);
        queue_random(470, 65);
        drain();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
